// ===== rtl/stereo_pan_gain_stage_defines.svh =====
// assertion macros for the stereo pan gain stage
`ifndef STEREO_PAN_GAIN_STAGE_DEFINES_SVH
`define STEREO_PAN_GAIN_STAGE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("stereo pan gain stage check failed");

// next-cycle implication, checked out of reset
`define SPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("stereo pan gain stage check failed");

`endif

// ===== rtl/spg_pkg.sv =====
// shared types and constants of the stereo pan gain stage
`default_nettype none

package spg_pkg;

    localparam int NUM_VOICES = 32;

    localparam int VIDX_W  = 5;
    localparam int LEVEL_W = 16;
    localparam int BYTE_W  = 8;
    localparam int BASE_W  = 16;
    localparam int TA_W    = 17;

    localparam logic [15:0] CURVE_A  = 16'h4ac8;
    localparam logic [15:0] CURVE_B  = 16'hb538;
    localparam logic [15:0] CURVE_C  = 16'hb818;
    localparam logic [6:0]  SEG_SPAN = 7'h40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_PAN_BASE     = 1'b0;
    localparam logic REG_PAN_BASE_ALT = 1'b1;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic [BYTE_W-1:0] vol;
        logic [TA_W-1:0]   t_left;
        logic [TA_W-1:0]   t_right;
        logic              mono;
        logic              alt;
    } t_s1;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic [BYTE_W-1:0] vol;
        logic [BYTE_W-1:0] g_left;
        logic [BYTE_W-1:0] g_right;
        logic              mono;
        logic              alt;
    } t_s2;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic [BYTE_W-1:0] vol;
        logic [BYTE_W-1:0] g_left;
        logic [BYTE_W-1:0] g_right;
        logic              mono;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/spg_vol_curve.sv =====
// first stage: scaled volume and pan curve factors
`default_nettype none

module spg_vol_curve (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [spg_pkg::VIDX_W-1:0]    i_voice_index,
    input  wire logic [spg_pkg::LEVEL_W-1:0]   i_level_word,
    input  wire logic [spg_pkg::BYTE_W-1:0]    i_volume_scale,
    input  wire logic [spg_pkg::BYTE_W-1:0]    i_pan_position,
    input  wire logic                          i_use_alt_base,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output spg_pkg::t_s1                       o_data
);

    logic              r_valid;
    spg_pkg::t_s1      r_data;
    spg_pkg::t_s1      n_data;

    logic [7:0]  lvl;
    logic [8:0]  lvl_inc;
    logic [16:0] vol_prod;
    logic        seg_left;
    logic [6:0]  fac_a;
    logic [5:0]  fac_c;
    logic [22:0] prod_a;
    logic [21:0] prod_c;
    logic [spg_pkg::TA_W-1:0] t_a;
    logic [spg_pkg::TA_W-1:0] t_c;

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        lvl      = i_level_word[15:8];
        lvl_inc  = (lvl == 8'd0) ? 9'd0 : ({1'b0, lvl} + 9'd1);
        vol_prod = 17'(i_volume_scale) * 17'(lvl_inc);

        seg_left = ~i_pan_position[6];
        // left half: a side runs 64-p, right half: p-63
        fac_a    = seg_left ? (spg_pkg::SEG_SPAN - i_pan_position[6:0])
                            : ({1'b0, i_pan_position[5:0]} + 7'd1);
        // left half: c side runs p, right half: 127-p
        fac_c    = seg_left ? i_pan_position[5:0] : ~i_pan_position[5:0];
        prod_a   = 23'(fac_a) * 23'(spg_pkg::CURVE_A);
        prod_c   = 22'(fac_c) * 22'(spg_pkg::CURVE_C);
        t_a      = prod_a[22:6] + 17'(spg_pkg::CURVE_B);
        t_c      = 17'(prod_c[21:6]);

        n_data.vidx = i_voice_index;
        n_data.vol  = vol_prod[15:8];
        n_data.alt  = i_use_alt_base;
        n_data.mono = i_pan_position[7];
        if (i_pan_position[7]) begin
            n_data.t_left  = 17'(spg_pkg::CURVE_B);
            n_data.t_right = 17'(spg_pkg::CURVE_B);
        end else if (seg_left) begin
            n_data.t_left  = t_a;
            n_data.t_right = t_c;
        end else begin
            n_data.t_left  = t_c;
            n_data.t_right = t_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spg_pan_mul.sv =====
// second stage: pan factors times scaled volume
`default_nettype none

module spg_pan_mul (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire spg_pkg::t_s1  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output spg_pkg::t_s2       o_data
);

    logic              r_valid;
    spg_pkg::t_s2      r_data;
    spg_pkg::t_s2      n_data;
    logic [24:0]       prod_l;
    logic [24:0]       prod_r;

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        prod_l         = 25'(i_data.t_left) * 25'(i_data.vol);
        prod_r         = 25'(i_data.t_right) * 25'(i_data.vol);
        n_data.vidx    = i_data.vidx;
        n_data.vol     = i_data.vol;
        n_data.g_left  = prod_l[23:16];
        n_data.g_right = prod_r[23:16];
        n_data.mono    = i_data.mono;
        n_data.alt     = i_data.alt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spg_base_mul.sv =====
// third stage: gains times master base, output register
`default_nettype none

module spg_base_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire spg_pkg::t_s2                 i_data,
    input  wire logic [spg_pkg::BASE_W-1:0]   i_pan_base,
    input  wire logic [spg_pkg::BASE_W-1:0]   i_pan_base_alt,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output spg_pkg::t_res                     o_data
);

    logic              r_valid;
    spg_pkg::t_res     r_data;
    spg_pkg::t_res     n_data;
    logic [spg_pkg::BASE_W-1:0] base;
    logic [23:0]       prod_l;
    logic [23:0]       prod_r;

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        base           = i_data.alt ? i_pan_base_alt : i_pan_base;
        prod_l         = 24'(i_data.g_left) * 24'(base);
        prod_r         = 24'(i_data.g_right) * 24'(base);
        n_data.vidx    = i_data.vidx;
        n_data.vol     = i_data.vol;
        n_data.g_left  = prod_l[15:8];
        n_data.g_right = prod_r[15:8];
        n_data.mono    = i_data.mono;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stereo_pan_gain_stage.sv =====
// Stereo pan gain stage: per voice, forms the scaled volume from the upper
// byte of the level word and the volume scale, maps the pan position through
// a three-segment curve (left half, right half, mono from 128 up) into left
// and right gains, and scales both by the master base that the voice selects.
// Three register stages (volume and curve factors, pan multiply, base multiply
// with the output register) take one item per clock while the output is not
// stalled. A stall holds the pipeline only where a stage is full, so bubbles
// are squeezed out. Items with voice_present low, or a voice index at or above
// the voice count, are accepted and give no result. The two base registers sit
// on the APB port at byte addresses 0 and 4 and should be written while no
// item is in flight.
`default_nettype none

`include "stereo_pan_gain_stage_defines.svh"

module stereo_pan_gain_stage #(
    parameter int NUM_VOICES = spg_pkg::NUM_VOICES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [spg_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [spg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [spg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,

    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [spg_pkg::VIDX_W-1:0]        i_voice_index,
    input  wire logic                              i_voice_present,
    input  wire logic [spg_pkg::LEVEL_W-1:0]       i_level_word,
    input  wire logic [spg_pkg::BYTE_W-1:0]        i_volume_scale,
    input  wire logic [spg_pkg::BYTE_W-1:0]        i_pan_position,
    input  wire logic                              i_use_alt_base,

    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [spg_pkg::VIDX_W-1:0]        o_out_voice_index,
    output logic      [spg_pkg::BYTE_W-1:0]        o_volume_scaled,
    output logic      [spg_pkg::BYTE_W-1:0]        o_gain_left,
    output logic      [spg_pkg::BYTE_W-1:0]        o_gain_right,
    output logic                                   o_mono_flag
);

    logic [spg_pkg::BASE_W-1:0] r_pan_base;
    logic [spg_pkg::BASE_W-1:0] r_pan_base_alt;
    logic                       cfg_wr;
    logic                       voice_ok;

    logic          s1_valid;
    logic          s1_stall;
    spg_pkg::t_s1  s1_data;
    logic          s2_valid;
    logic          s2_stall;
    spg_pkg::t_s2  s2_data;
    spg_pkg::t_res res;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_base     <= '0;
            r_pan_base_alt <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                spg_pkg::REG_PAN_BASE:     r_pan_base     <= pwdata[spg_pkg::BASE_W-1:0];
                spg_pkg::REG_PAN_BASE_ALT: r_pan_base_alt <= pwdata[spg_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            spg_pkg::REG_PAN_BASE:     prdata = 32'(r_pan_base);
            spg_pkg::REG_PAN_BASE_ALT: prdata = 32'(r_pan_base_alt);
            default:                   prdata = '0;
        endcase
    end

    // absent or out-of-range voices are dropped at entry
    assign voice_ok = i_voice_present &
                      ({4'd0, i_voice_index} < 9'(NUM_VOICES));

    spg_vol_curve u_vol_curve (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid & voice_ok),
        .o_stall        (o_stall),
        .i_voice_index  (i_voice_index),
        .i_level_word   (i_level_word),
        .i_volume_scale (i_volume_scale),
        .i_pan_position (i_pan_position),
        .i_use_alt_base (i_use_alt_base),
        .o_valid        (s1_valid),
        .i_stall        (s1_stall),
        .o_data         (s1_data)
    );

    spg_pan_mul u_pan_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_stall (s1_stall),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_stall (s2_stall),
        .o_data  (s2_data)
    );

    spg_base_mul u_base_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s2_valid),
        .o_stall        (s2_stall),
        .i_data         (s2_data),
        .i_pan_base     (r_pan_base),
        .i_pan_base_alt (r_pan_base_alt),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data         (res)
    );

    assign o_out_voice_index = res.vidx;
    assign o_volume_scaled   = res.vol;
    assign o_gain_left       = res.g_left;
    assign o_gain_right      = res.g_right;
    assign o_mono_flag       = res.mono;

    `SPG_ASSERT_NEXT(a_absent_dropped, i_valid && !o_stall && !i_voice_present, !s1_valid)
    `SPG_ASSERT_SAME(a_mono_equal, o_valid && o_mono_flag, o_gain_left == o_gain_right)
    `SPG_ASSERT_SAME(a_silent_zero, o_valid && (o_volume_scaled == 8'd0),
                     (o_gain_left == 8'd0) && (o_gain_right == 8'd0))

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the stereo pan gain stage: table of directed voices, then random phases
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RESET_ROWS    = 4;
    localparam int NUM_ROWS      = 20;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_VOICES  = 160;
    localparam int LEFT_END      = 63;
    localparam int RIGHT_END     = 127;

    typedef struct packed {
        logic [spg_pkg::VIDX_W-1:0]  vidx;
        logic                        present;
        logic [spg_pkg::LEVEL_W-1:0] level;
        logic [spg_pkg::BYTE_W-1:0]  scale;
        logic [spg_pkg::BYTE_W-1:0]  pan;
        logic                        alt;
    } t_voice_item;

    typedef struct packed {
        t_voice_item   item;
        logic          typed;
        spg_pkg::t_res gains;
    } t_stim_row;

    localparam spg_pkg::t_res NO_GAINS = '0;

    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        '{'{5'd0,  1'b1, 16'hffff, 8'd255, 8'd0,   1'b0}, 1'b1, '{5'd0,  8'd255, 8'd0, 8'd0, 1'b0}},
        '{'{5'd31, 1'b1, 16'h0000, 8'd255, 8'd200, 1'b1}, 1'b1, '{5'd31, 8'd0, 8'd0, 8'd0, 1'b1}},
        '{'{5'd5,  1'b0, 16'hffff, 8'd255, 8'd255, 1'b1}, 1'b0, NO_GAINS},
        '{'{5'd7,  1'b1, 16'h00ff, 8'd255, 8'd64,  1'b0}, 1'b1, '{5'd7,  8'd0, 8'd0, 8'd0, 1'b0}},
        '{'{5'd1,  1'b1, 16'hffff, 8'd255, 8'd0,   1'b0}, 1'b1,
          '{5'd1, 8'd255, 8'd255, 8'd0, 1'b0}},
        '{'{5'd2,  1'b1, 16'hffff, 8'd255, 8'd127, 1'b0}, 1'b1,
          '{5'd2, 8'd255, 8'd0, 8'd255, 1'b0}},
        '{'{5'd3,  1'b1, 16'hffff, 8'd255, 8'd255, 1'b0}, 1'b1,
          '{5'd3, 8'd255, 8'd180, 8'd180, 1'b1}},
        '{'{5'd4,  1'b1, 16'hffff, 8'd255, 8'd128, 1'b0}, 1'b1,
          '{5'd4, 8'd255, 8'd180, 8'd180, 1'b1}},
        '{'{5'd8,  1'b1, 16'hffff, 8'd255, 8'd63,  1'b0}, 1'b0, NO_GAINS},
        '{'{5'd9,  1'b1, 16'hffff, 8'd255, 8'd64,  1'b0}, 1'b0, NO_GAINS},
        '{'{5'd10, 1'b1, 16'hffff, 8'd255, 8'd63,  1'b1}, 1'b0, NO_GAINS},
        '{'{5'd11, 1'b1, 16'hffff, 8'd255, 8'd64,  1'b1}, 1'b0, NO_GAINS},
        '{'{5'd12, 1'b1, 16'h0100, 8'd1,   8'd0,   1'b0}, 1'b1, '{5'd12, 8'd0, 8'd0, 8'd0, 1'b0}},
        '{'{5'd13, 1'b1, 16'h0100, 8'd255, 8'd32,  1'b1}, 1'b0, NO_GAINS},
        '{'{5'd14, 1'b1, 16'h8000, 8'd128, 8'd96,  1'b1}, 1'b0, NO_GAINS},
        '{'{5'd15, 1'b0, 16'h1234, 8'h55,  8'd10,  1'b0}, 1'b0, NO_GAINS},
        '{'{5'd30, 1'b1, 16'haaaa, 8'haa,  8'haa,  1'b1}, 1'b0, NO_GAINS},
        '{'{5'd21, 1'b1, 16'h5555, 8'h55,  8'h55,  1'b0}, 1'b0, NO_GAINS},
        '{'{5'd0,  1'b1, 16'hffff, 8'd0,   8'd0,   1'b1}, 1'b1, '{5'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
        '{'{5'd31, 1'b1, 16'hffff, 8'd255, 8'd255, 1'b1}, 1'b0, NO_GAINS}
    };

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [spg_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [spg_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [spg_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    logic                           i_valid  = 1'b0;
    logic                           o_stall;
    t_voice_item                    drv_item = '0;
    logic                           drv_typed = 1'b0;
    spg_pkg::t_res                  drv_gains = '0;

    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [spg_pkg::VIDX_W-1:0]     o_out_voice_index;
    logic [spg_pkg::BYTE_W-1:0]     o_volume_scaled;
    logic [spg_pkg::BYTE_W-1:0]     o_gain_left;
    logic [spg_pkg::BYTE_W-1:0]     o_gain_right;
    logic                           o_mono_flag;

    logic [spg_pkg::BASE_W-1:0]     base_main = '0;
    logic [spg_pkg::BASE_W-1:0]     base_alt  = '0;
    spg_pkg::t_res                  pending_gains [$];
    int                             mismatches = 0;
    int                             quiet_cycles = 0;
    int                             send_idle_pct = 0;
    int                             recv_stall_pct = 0;

    stereo_pan_gain_stage dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_voice_index     (drv_item.vidx),
        .i_voice_present   (drv_item.present),
        .i_level_word      (drv_item.level),
        .i_volume_scale    (drv_item.scale),
        .i_pan_position    (drv_item.pan),
        .i_use_alt_base    (drv_item.alt),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_voice_index (o_out_voice_index),
        .o_volume_scaled   (o_volume_scaled),
        .o_gain_left       (o_gain_left),
        .o_gain_right      (o_gain_right),
        .o_mono_flag       (o_mono_flag)
    );

    always #10 i_clk = ~i_clk;

    function automatic spg_pkg::t_res pan_gain_predict(t_voice_item it);
        spg_pkg::t_res r;
        int unsigned   lvl, vol, p, t, gl, gr, base;
        int unsigned   ca, cb, cc, span;
        int unsigned   out_l, out_r;
        ca   = 32'(spg_pkg::CURVE_A);
        cb   = 32'(spg_pkg::CURVE_B);
        cc   = 32'(spg_pkg::CURVE_C);
        span = 32'(spg_pkg::SEG_SPAN);
        p    = 32'(it.pan);
        lvl  = 32'(it.level[15:8]);
        if (lvl != 0) begin
            lvl++;
        end
        vol = ((32'(it.scale) * lvl) >> 8) & 32'hff;
        if (p <= LEFT_END) begin
            t  = (((span - p) * ca) >> 6) + cb;
            gl = ((t * vol) >> 16) & 32'hff;
            t  = (cc * p) >> 6;
            gr = ((t * vol) >> 16) & 32'hff;
        end else if (p <= RIGHT_END) begin
            t  = ((RIGHT_END - p) * cc) >> 6;
            gl = ((t * vol) >> 16) & 32'hff;
            t  = (((p - LEFT_END) * ca) >> 6) + cb;
            gr = ((t * vol) >> 16) & 32'hff;
        end else begin
            gr = ((cb * vol) >> 16) & 32'hff;
            gl = gr;
        end
        base      = it.alt ? 32'(base_alt) : 32'(base_main);
        out_l     = (gl * base) >> 8;
        out_r     = (gr * base) >> 8;
        r.vidx    = it.vidx;
        r.vol     = vol[7:0];
        r.g_left  = out_l[7:0];
        r.g_right = out_r[7:0];
        r.mono    = (p > RIGHT_END);
        return r;
    endfunction

    function automatic t_voice_item random_voice();
        t_voice_item it;
        it.vidx    = 5'($urandom_range(0, spg_pkg::NUM_VOICES - 1));
        it.present = ($urandom_range(1, 100) <= 92);
        it.alt     = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: it.level = 16'($urandom_range(0, 255));
            1: it.level = 16'hffff;
            default: it.level = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0: it.scale = 8'd0;
            1: it.scale = 8'd255;
            default: it.scale = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
            0: it.pan = 8'($urandom_range(0, LEFT_END));
            1: it.pan = 8'($urandom_range(LEFT_END + 1, RIGHT_END));
            2: it.pan = 8'($urandom_range(RIGHT_END + 1, 255));
            default: begin
                case ($urandom_range(0, 5))
                    0: it.pan = 8'd0;
                    1: it.pan = 8'd63;
                    2: it.pan = 8'd64;
                    3: it.pan = 8'd127;
                    4: it.pan = 8'd128;
                    default: it.pan = 8'd255;
                endcase
            end
        endcase
        return it;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic apb_cycle(input logic wr, input logic idx,
                             input logic [spg_pkg::APB_DATA_W-1:0] wdata,
                             output logic [spg_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_base(input logic idx, input logic [spg_pkg::BASE_W-1:0] value);
        logic [spg_pkg::APB_DATA_W-1:0] rd;
        string                          name;
        apb_cycle(1'b1, idx, {16'h0, value}, rd);
        if (idx == spg_pkg::REG_PAN_BASE_ALT) begin
            base_alt = value;
            name     = "pan_base_alt";
        end else begin
            base_main = value;
            name      = "pan_base";
        end
        apb_cycle(1'b0, idx, '0, rd);
        check_field(name, {16'h0, value}, rd);
    endtask

    task automatic send_voice(input t_voice_item it, input logic typed,
                              input spg_pkg::t_res gains);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        drv_item  <= it;
        drv_typed <= typed;
        drv_gains <= gains;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_gains.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(1, 100) <= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall && drv_item.present &&
            drv_item.vidx < spg_pkg::NUM_VOICES) begin
            pending_gains.push_back(drv_typed ? drv_gains : pan_gain_predict(drv_item));
        end
    end

    always @(posedge i_clk) begin
        spg_pkg::t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_gains.size() == 0) begin
                $error("result for voice %0d with no item waiting", o_out_voice_index);
                mismatches++;
            end else begin
                want = pending_gains.pop_front();
                check_field("out_voice_index", 32'(want.vidx), 32'(o_out_voice_index));
                check_field("volume_scaled", 32'(want.vol), 32'(o_volume_scaled));
                check_field("gain_left", 32'(want.g_left), 32'(o_gain_left));
                check_field("gain_right", 32'(want.g_right), 32'(o_gain_right));
                check_field("mono_flag", 32'(want.mono), 32'(o_mono_flag));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int          sent;
        t_voice_item it;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (r == RESET_ROWS) begin
                wait_idle();
                set_base(spg_pkg::REG_PAN_BASE, 16'h0100);
                set_base(spg_pkg::REG_PAN_BASE_ALT, 16'hffff);
            end
            send_voice(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].gains);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    set_base(spg_pkg::REG_PAN_BASE, 16'hffff);
                    set_base(spg_pkg::REG_PAN_BASE_ALT, 16'h0000);
                end
                1: begin
                    set_base(spg_pkg::REG_PAN_BASE, 16'h0000);
                    set_base(spg_pkg::REG_PAN_BASE_ALT, 16'hffff);
                end
                2: begin
                    set_base(spg_pkg::REG_PAN_BASE, 16'h0100);
                    set_base(spg_pkg::REG_PAN_BASE_ALT, 16'h0080);
                end
                default: begin
                    set_base(spg_pkg::REG_PAN_BASE, 16'($urandom_range(0, 65535)));
                    set_base(spg_pkg::REG_PAN_BASE_ALT, 16'($urandom_range(0, 65535)));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            sent = 0;
            while (sent < PHASE_VOICES) begin
                it = random_voice();
                send_voice(it, 1'b0, NO_GAINS);
                if (it.present) begin
                    sent++;
                end
                // hold off mid-phase until the pipe has drained
                if (ph == 2 && sent == PHASE_VOICES / 2 && it.present) begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && pending_gains.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
